/* hdl/dctq_pkg.sv */
// ----------------------------------------------------------------------------
// dctq_pkg
// Shared constants, codes and the stored entry layout of the delta-clock
// timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dctq_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int DELAY_W  = 16;
  localparam int ID_W     = 8;
  localparam int KIND_W   = 1;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 7;
  localparam int COUNT_W  = 8;

  // request payload: delay, event_id
  localparam int IN_DATA_W  = 24;
  // result payload: position, popped_id, head_delay, head_id, entry_count, pad
  localparam int OUT_DATA_W = 48;

  localparam logic [KIND_W-1:0] KIND_INSERT = 1'b0;
  localparam logic [KIND_W-1:0] KIND_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delay;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* hdl/dctq_ram.sv */
// ----------------------------------------------------------------------------
// dctq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dctq_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hdl/delta_clock_timer_queue.sv */
// ----------------------------------------------------------------------------
// delta_clock_timer_queue
// Ordered timer list kept as relative delays in one entry RAM.
// ----------------------------------------------------------------------------
// Insert: walk the pending entries, shift the entries behind the slot up, place,
//   head read, capture.
// Pop: take entry 0, shift the rest down, head read, capture. Dropped insert or empty pop: head read and capture only.
// Next request is taken the cycle after a result is registered; a result not
//   yet taken holds the following one in capture. Reset empties the list at
//   once; the RAM itself is not cleared.
`default_nettype none

module delta_clock_timer_queue (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [dctq_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // delay[15:0], event_id[23:16]
  input  wire logic [dctq_pkg::KIND_W-1:0]     s_axis_tuser,  // kind[0]
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // position[6:0], popped_id[14:7], head_delay[30:15], head_id[38:31],
  // entry_count[46:39], zero[47]
  output logic [dctq_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [dctq_pkg::STATUS_W-1:0]        m_axis_tuser   // status[1:0]
);

  import dctq_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_WALK   = 4'd1;
  localparam logic [3:0] ST_SHIFT  = 4'd2;
  localparam logic [3:0] ST_PLACE  = 4'd3;
  localparam logic [3:0] ST_POP0   = 4'd4;
  localparam logic [3:0] ST_PSHIFT = 4'd5;
  localparam logic [3:0] ST_HEAD   = 4'd6;
  localparam logic [3:0] ST_HCAP   = 4'd7;

  logic [3:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    j_q, j_d;
  logic [DELAY_W-1:0]  remain_q, remain_d;
  logic [ID_W-1:0]     id_q, id_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [ID_W-1:0]     popped_q, popped_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [POS_W-1:0]    out_pos_q, out_pos_d;
  logic [ID_W-1:0]     out_popped_q, out_popped_d;
  logic [DELAY_W-1:0]  out_hdelay_q, out_hdelay_d;
  logic [ID_W-1:0]     out_hid_q, out_hid_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  entry_t              ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              rd_entry;

  logic                in_fire;
  logic [DELAY_W-1:0]  in_delay;
  logic [ID_W-1:0]     in_id;
  logic [KIND_W-1:0]   in_kind;

  assign in_delay = s_axis_tdata[DELAY_W-1:0];
  assign in_id    = s_axis_tdata[DELAY_W +: ID_W];
  assign in_kind  = s_axis_tuser;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign rd_entry = entry_t'(ram_rdata);

  dctq_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    j_d          = j_q;
    remain_d     = remain_q;
    id_d         = id_q;
    status_d     = status_q;
    popped_d     = popped_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_popped_d = out_popped_q;
    out_hdelay_d = out_hdelay_q;
    out_hid_d    = out_hid_q;
    out_count_d  = out_count_q;
    ram_we       = 1'b0;
    ram_waddr    = ADDR_W'(idx_q);
    ram_wdata    = rd_entry;
    ram_raddr    = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          remain_d = in_delay;
          id_d     = in_id;
          idx_d    = '0;
          popped_d = '0;
          status_d = STAT_OK;
          if (in_kind == KIND_INSERT) begin
            if (count_q == CNT_W'(QUEUE_DEPTH)) begin
              status_d = STAT_FULL;
              state_d  = ST_HEAD;
            end else begin
              state_d = ST_WALK;
            end
          end else begin
            if (count_q == '0) begin
              status_d = STAT_EMPTY;
              state_d  = ST_HEAD;
            end else begin
              state_d = ST_POP0;
            end
          end
        end
      end
      ST_WALK: begin
        // read data holds entry idx_q; prefetch the next one while walking
        if ((idx_q < count_q) && (remain_q >= rd_entry.delay)) begin
          remain_d  = remain_q - rd_entry.delay;
          idx_d     = idx_q + CNT_W'(1);
          ram_raddr = ADDR_W'(idx_q + CNT_W'(1));
        end else begin
          ram_raddr = ADDR_W'(count_q - CNT_W'(1));
          j_d       = count_q;
          state_d   = (idx_q < count_q) ? ST_SHIFT : ST_PLACE;
        end
      end
      ST_SHIFT: begin
        // move entry j-1 to j, tail first
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(j_q);
        ram_wdata = rd_entry;
        if (j_q == idx_q + CNT_W'(1)) begin
          ram_wdata.delay = rd_entry.delay - remain_q;
          state_d         = ST_PLACE;
        end else begin
          ram_raddr = ADDR_W'(j_q - CNT_W'(2));
          j_d       = j_q - CNT_W'(1);
        end
      end
      ST_PLACE: begin
        ram_we          = 1'b1;
        ram_waddr       = ADDR_W'(idx_q);
        ram_wdata.delay = remain_q;
        ram_wdata.id    = id_q;
        count_d         = count_q + CNT_W'(1);
        state_d         = ST_HEAD;
      end
      ST_POP0: begin
        popped_d = rd_entry.id;
        count_d  = count_q - CNT_W'(1);
        if (count_q == CNT_W'(1)) begin
          state_d = ST_HEAD;
        end else begin
          ram_raddr = ADDR_W'(1);
          j_d       = '0;
          state_d   = ST_PSHIFT;
        end
      end
      ST_PSHIFT: begin
        // move entry j+1 to j, head first; count_q already holds the new count
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(j_q);
        ram_wdata = rd_entry;
        if (j_q == count_q - CNT_W'(1)) begin
          state_d = ST_HEAD;
        end else begin
          ram_raddr = ADDR_W'(j_q + CNT_W'(2));
          j_d       = j_q + CNT_W'(1);
        end
      end
      ST_HEAD: begin
        ram_raddr = '0;
        state_d   = ST_HCAP;
      end
      ST_HCAP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_pos_d    = POS_W'(idx_q);
          out_popped_d = popped_q;
          out_hdelay_d = (count_q != '0) ? rd_entry.delay : '0;
          out_hid_d    = (count_q != '0) ? rd_entry.id : '0;
          out_count_d  = COUNT_W'(count_q);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    j_q          <= j_d;
    remain_q     <= remain_d;
    id_q         <= id_d;
    status_q     <= status_d;
    popped_q     <= popped_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_popped_q <= out_popped_d;
    out_hdelay_q <= out_hdelay_d;
    out_hid_q    <= out_hid_d;
    out_count_q  <= out_count_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_hid_q, out_hdelay_q, out_popped_q, out_pos_q};

endmodule

`default_nettype wire

/* hdl/dctq_checker.sv */
// ----------------------------------------------------------------------------
// dctq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dctq_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [dctq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [dctq_pkg::STATUS_W-1:0]   m_axis_tuser
);

  import dctq_pkg::*;

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

  // one request in flight: after an accept the input side closes
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while busy");

  // count never exceeds the list size
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[46:39] <= COUNT_W'(QUEUE_DEPTH)))
    else $error("entry count beyond depth");

  // an empty list shows a zero head
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[46:39] == '0)) |->
      ((m_axis_tdata[30:15] == '0) && (m_axis_tdata[38:31] == '0)))
    else $error("nonzero head on empty list");

  // dropped insert and ignored pop report no position or popped id
  a_reject_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ((m_axis_tuser == STAT_FULL) || (m_axis_tuser == STAT_EMPTY))) |->
      ((m_axis_tdata[6:0] == '0) && (m_axis_tdata[14:7] == '0)))
    else $error("rejected request reports fields");

endmodule

bind delta_clock_timer_queue dctq_checker u_dctq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
